### hw/rtl/abad_pkg.sv
`default_nettype none

package abad_pkg;

  localparam int RANGE_W       = 64;
  localparam int PROB_W        = 32;
  localparam int PRELOAD_W     = 4;
  localparam int PRELOAD_BYTES = 8;
  localparam int DIV_CNT_W     = $clog2(PROB_W);

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEED_BYTE = 2'd1,
    ST_NO_BYTE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_SPLIT,
    S_RESOLVE,
    S_WRITE,
    S_READ,
    S_DIVINIT,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic diff_ld;
    logic mul_ld;
    logic split_ld;
    logic resolve;
    logic count_wr;
    logic div_init;
    logic div_step;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic go_decode;
    logic clr_last;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/abad_ctrl.sv
`default_nettype none

module abad_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          out_stall_i,
  input  wire abad_pkg::sts_t sts_i,
  output abad_pkg::cmd_t     cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);

  abad_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      abad_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = abad_pkg::S_IDLE;
      end
      abad_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.go_decode ? abad_pkg::S_DIFF : abad_pkg::S_DONE;
        end
      end
      abad_pkg::S_DIFF:    state_d = abad_pkg::S_MUL;
      abad_pkg::S_MUL:     state_d = abad_pkg::S_SPLIT;
      abad_pkg::S_SPLIT:   state_d = abad_pkg::S_RESOLVE;
      abad_pkg::S_RESOLVE: state_d = abad_pkg::S_WRITE;
      abad_pkg::S_WRITE:   state_d = abad_pkg::S_READ;
      abad_pkg::S_READ:    state_d = abad_pkg::S_DIVINIT;
      abad_pkg::S_DIVINIT: state_d = abad_pkg::S_DIV;
      abad_pkg::S_DIV: begin
        if (sts_i.div_last) state_d = abad_pkg::S_DONE;
      end
      abad_pkg::S_DONE: begin
        if (out_free) state_d = abad_pkg::S_IDLE;
      end
      default: state_d = abad_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      abad_pkg::S_CLEAR:   cmd_o.clr_wr = 1'b1;
      abad_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      abad_pkg::S_DIFF:    cmd_o.diff_ld  = 1'b1;
      abad_pkg::S_MUL:     cmd_o.mul_ld   = 1'b1;
      abad_pkg::S_SPLIT:   cmd_o.split_ld = 1'b1;
      abad_pkg::S_RESOLVE: cmd_o.resolve  = 1'b1;
      abad_pkg::S_WRITE:   cmd_o.count_wr = 1'b1;
      abad_pkg::S_READ:    cmd_o          = '0;
      abad_pkg::S_DIVINIT: cmd_o.div_init = 1'b1;
      abad_pkg::S_DIV:     cmd_o.div_step = 1'b1;
      abad_pkg::S_DONE:    cmd_o.out_ld   = out_free;
      default:             cmd_o          = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abad_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/abad_dp.sv
`default_nettype none

module abad_dp #(
  parameter int CONTEXT_BITS = 8,
  parameter int COUNT_BITS   = 28
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire abad_pkg::cmd_t cmd_i,
  output abad_pkg::sts_t      sts_o,
  input  wire logic           operation_i,
  input  wire logic [7:0]     data_byte_i,
  output logic                decoded_bit_o,
  output logic                need_byte_o,
  output logic [1:0]          status_o
);

  localparam int DEPTH = 1 << CONTEXT_BITS;
  localparam int ROW_W = 2 * COUNT_BITS;
  localparam int DEN_W = COUNT_BITS + 2;
  localparam int REM_W = COUNT_BITS + 3;
  localparam int RW    = abad_pkg::RANGE_W;
  localparam int PW    = abad_pkg::PROB_W;
  localparam int CW    = abad_pkg::DIV_CNT_W;
  localparam int LW    = abad_pkg::PRELOAD_W;

  logic [RW-1:0]           lo_q, hi_q, code_q;
  logic [PW-1:0]           prob_q;
  logic [CONTEXT_BITS-1:0] ctx_q;
  logic [LW-1:0]           preload_q;

  logic [PW-1:0]           diff_q;
  logic [RW-1:0]           prod_q;
  logic [RW-1:0]           split_q;
  logic                    bit_q;
  abad_pkg::status_e       status_q;
  logic [ROW_W-1:0]        rd_q;
  logic [DEN_W-1:0]        den_q;
  logic [REM_W-1:0]        rem_q;
  logic [PW-1:0]           quo_q;
  logic [CW-1:0]           div_cnt_q;
  logic [CONTEXT_BITS-1:0] clr_addr_q;

  logic                    decoded_bit_q, need_byte_q;
  abad_pkg::status_e       status_out_q;

  logic [ROW_W-1:0]        mem [DEPTH];

  logic                    wanted, preloading, push_ok;
  logic [RW-1:0]           diff_full, prod_d;
  logic [COUNT_BITS-1:0]   z_cur, o_cur, hit, other, hit_new, other_new;
  logic [COUNT_BITS:0]     hit_inc;
  logic [COUNT_BITS-1:0]   z_new, o_new;
  logic                    mem_we;
  logic [CONTEXT_BITS-1:0] mem_waddr;
  logic [ROW_W-1:0]        mem_wdata;
  logic [REM_W-1:0]        rem_sh, den_ext, rem_nx;
  logic                    quo_bit;
  logic [PW-1:0]           quo_nx;

  assign preloading = preload_q < LW'(abad_pkg::PRELOAD_BYTES);
  assign wanted     = preloading || (lo_q[RW-1 -: 8] == hi_q[RW-1 -: 8]);
  assign push_ok    = (operation_i == abad_pkg::OP_PUSH) && wanted;

  assign sts_o.go_decode = (operation_i == abad_pkg::OP_DECODE) && !wanted;
  assign sts_o.clr_last  = &clr_addr_q;
  assign sts_o.div_last  = &div_cnt_q;

  assign diff_full = hi_q - lo_q;
  assign prod_d    = diff_q * prob_q;

  assign z_cur   = rd_q[ROW_W-1:COUNT_BITS];
  assign o_cur   = rd_q[COUNT_BITS-1:0];
  assign hit     = bit_q ? o_cur : z_cur;
  assign other   = bit_q ? z_cur : o_cur;
  assign hit_inc = {1'b0, hit} + (COUNT_BITS + 1)'(1);

  always_comb begin
    if (hit_inc[COUNT_BITS]) begin
      hit_new   = hit_inc[COUNT_BITS:1];
      other_new = other >> 1;
    end else begin
      hit_new   = hit_inc[COUNT_BITS-1:0];
      other_new = other;
    end
    z_new = bit_q ? other_new : hit_new;
    o_new = bit_q ? hit_new : other_new;
  end

  assign mem_we    = cmd_i.clr_wr || cmd_i.count_wr;
  assign mem_waddr = cmd_i.clr_wr ? clr_addr_q : ctx_q;
  assign mem_wdata = cmd_i.clr_wr ? '0 : {z_new, o_new};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[ctx_q];
  end

  assign rem_sh  = {rem_q[REM_W-2:0], 1'b0};
  assign den_ext = {1'b0, den_q};
  assign quo_bit = rem_sh >= den_ext;
  assign rem_nx  = quo_bit ? rem_sh - den_ext : rem_sh;
  assign quo_nx  = {quo_q[PW-2:0], quo_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q       <= '0;
      hi_q       <= '1;
      code_q     <= '0;
      prob_q     <= '1;
      ctx_q      <= '0;
      preload_q  <= '0;
      div_cnt_q  <= '0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + CONTEXT_BITS'(1);
      if (cmd_i.accept && push_ok) begin
        code_q <= {code_q[RW-9:0], data_byte_i};
        if (preloading) begin
          preload_q <= preload_q + LW'(1);
        end else begin
          lo_q <= {lo_q[RW-9:0], 8'h00};
          hi_q <= {hi_q[RW-9:0], 8'hff};
        end
      end
      if (cmd_i.resolve) begin
        if (code_q <= split_q) begin
          hi_q <= split_q;
        end else begin
          lo_q <= split_q + RW'(1);
        end
      end
      if (cmd_i.count_wr) ctx_q <= CONTEXT_BITS'({ctx_q, bit_q});
      if (cmd_i.div_init) div_cnt_q <= '0;
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + CW'(1);
        if (sts_o.div_last) prob_q <= quo_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bit_q <= 1'b0;
      if (operation_i == abad_pkg::OP_PUSH) begin
        status_q <= wanted ? abad_pkg::ST_OK : abad_pkg::ST_NO_BYTE;
      end else begin
        status_q <= wanted ? abad_pkg::ST_NEED_BYTE : abad_pkg::ST_OK;
      end
    end
    if (cmd_i.diff_ld)  diff_q  <= diff_full[RW-1:RW-PW];
    if (cmd_i.mul_ld)   prod_q  <= prod_d;
    if (cmd_i.split_ld) split_q <= lo_q + prod_q;
    if (cmd_i.resolve)  bit_q   <= code_q <= split_q;
    if (cmd_i.div_init) begin
      den_q <= DEN_W'(z_cur) + DEN_W'(o_cur) + DEN_W'(2);
      rem_q <= REM_W'(o_cur) + REM_W'(1);
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
    if (cmd_i.out_ld) begin
      decoded_bit_q <= bit_q;
      need_byte_q   <= wanted;
      status_out_q  <= status_q;
    end
  end

  assign decoded_bit_o = decoded_bit_q;
  assign need_byte_o   = need_byte_q;
  assign status_o      = status_out_q;

endmodule

`default_nettype wire

### hw/rtl/adaptive_binary_arith_decoder.sv
// Channel  | Direction | Handshake                 | Payload
// request  | in        | in_valid_i / in_stall_o   | operation_i, data_byte_i
// result   | out       | out_valid_o / out_stall_i | decoded_bit_o, need_byte_o, status_o
//
// A push or a refused request passes through the accept state and the result load.
// An accepted decode steps through accept, range split, count update, table reread,
// divider init and the bit-serial divider of the next probability, then result load.
// After reset a clearing pass zeroes the whole count table under in_stall_o.
// A new request is taken while the previous result waits; the block holds
// that next result until out_stall_i drops.
`default_nettype none

module adaptive_binary_arith_decoder #(
  parameter int CONTEXT_BITS = 8,
  parameter int COUNT_BITS   = 28
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       operation_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            decoded_bit_o,
  output logic            need_byte_o,
  output logic [1:0]      status_o
);

  abad_pkg::cmd_t cmd;
  abad_pkg::sts_t sts;

  abad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  abad_dp #(
    .CONTEXT_BITS (CONTEXT_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .decoded_bit_o (decoded_bit_o),
    .need_byte_o   (need_byte_o),
    .status_o      (status_o)
  );

`ifndef SYNTH
  a_bit_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decoded_bit_o |-> status_o == abad_pkg::ST_OK)
    else $error("decoded bit set on a refused request");

  a_stall_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> in_stall_o)
    else $error("request taken while dividing");

  a_refused_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == abad_pkg::ST_NO_BYTE |-> !need_byte_o)
    else $error("push refused while a byte is needed");

  a_refused_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == abad_pkg::ST_NEED_BYTE |-> need_byte_o)
    else $error("decode refused while no byte is needed");
`endif

endmodule

`default_nettype wire
